FILE: src/rgb_to_gray4_bitplane_packer_defines.svh
// Assertion macros for the gray4 bit-plane packer.
// Used by the top level; expects clk and rst_n in scope.
`ifndef RGB_TO_GRAY4_BITPLANE_PACKER_DEFINES_SVH
`define RGB_TO_GRAY4_BITPLANE_PACKER_DEFINES_SVH

// same-cycle implication
`define R2G4_ASSERT_IMPL(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("r2g4 assertion failed");

// next-cycle implication
`define R2G4_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("r2g4 assertion failed");

`endif

FILE: src/r2g4_pkg.sv
// Shared types and constants for the gray4 bit-plane packer.
// No dependencies.
package r2g4_pkg;

  localparam int unsigned FRAME_PIXELS = 134400;
  localparam int unsigned CNT_W        = 15;
  localparam logic [CNT_W-1:0] LAST_BYTE_IDX = CNT_W'((FRAME_PIXELS / 8) - 1);

  localparam int unsigned SUM_W   = 18;
  localparam logic [SUM_W-1:0] WEIGHT_R = SUM_W'(259);
  localparam logic [SUM_W-1:0] WEIGHT_G = SUM_W'(487);
  localparam logic [SUM_W-1:0] WEIGHT_B = SUM_W'(254);
  // floor(x/1000) == (x * RECIP) >> RECIP_SHIFT, exact for x < 2^18
  localparam int unsigned RECIP_SHIFT = 28;
  localparam int unsigned RECIP_W     = 19;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(268436);
  localparam int unsigned PROD_W      = SUM_W + RECIP_W;

  localparam int unsigned THR_W = 9;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CW    = FIFO_AW + 1;

  localparam int unsigned CFG_AW = 4;
  localparam logic [1:0] REG_LEVEL1 = 2'd0;
  localparam logic [1:0] REG_LEVEL2 = 2'd1;
  localparam logic [1:0] REG_LEVEL3 = 2'd2;

  typedef struct packed {
    logic [THR_W-1:0] l1;
    logic [THR_W-1:0] l2;
    logic [THR_W-1:0] l3;
  } thr_t;

  typedef struct packed {
    logic [1:0] level;
    logic       frame_start;
  } q_entry_t;

  typedef struct packed {
    logic [FIFO_CW-1:0] count;
    logic               empty;
    logic               full;
  } fifo_stat_t;

endpackage

FILE: src/r2g4_front.sv
// Front end: accepts pixels, computes luma and quantizes to a 2-bit level.
// Depends on r2g4_pkg; pushes into r2g4_fifo under a credit count.
module r2g4_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [7:0]             in_red,
  input  logic [7:0]             in_green,
  input  logic [7:0]             in_blue,
  input  logic                   in_frame_start,
  input  r2g4_pkg::thr_t         thr,
  input  r2g4_pkg::fifo_stat_t   fstat,
  output logic                   push,
  output r2g4_pkg::q_entry_t     push_entry
);
  import r2g4_pkg::*;

  logic             s1_v_r, s2_v_r;
  logic [SUM_W-1:0] s1_sum_r, sum_nxt;
  logic             s1_fs_r, s2_fs_r;
  logic [7:0]       s2_luma_r, luma_nxt;
  logic [PROD_W-1:0] prod;
  logic [FIFO_CW-1:0] used;

  assign used     = fstat.count + FIFO_CW'(s1_v_r) + FIFO_CW'(s2_v_r);
  assign in_stall = (used >= FIFO_CW'(FIFO_DEPTH));

  assign sum_nxt = SUM_W'(in_red) * WEIGHT_R + SUM_W'(in_green) * WEIGHT_G
                 + SUM_W'(in_blue) * WEIGHT_B;
  assign prod     = PROD_W'(s1_sum_r) * PROD_W'(RECIP);
  assign luma_nxt = prod[RECIP_SHIFT +: 8];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= in_valid & ~in_stall;
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_sum_r  <= sum_nxt;
    s1_fs_r   <= in_frame_start;
    s2_luma_r <= luma_nxt;
    s2_fs_r   <= s1_fs_r;
  end

  always_comb begin
    logic [THR_W-1:0] l;
    l = {1'b0, s2_luma_r};
    if (l < thr.l1)      push_entry.level = 2'd0;
    else if (l < thr.l2) push_entry.level = 2'd1;
    else if (l < thr.l3) push_entry.level = 2'd2;
    else                 push_entry.level = 2'd3;
    push_entry.frame_start = s2_fs_r;
  end

  assign push = s2_v_r;

endmodule

FILE: src/r2g4_fifo.sv
// Short queue of quantized pixels between front end and packer.
// Depends on r2g4_pkg.
module r2g4_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  r2g4_pkg::q_entry_t   push_entry,
  input  logic                 pop,
  output r2g4_pkg::q_entry_t   pop_entry,
  output r2g4_pkg::fifo_stat_t fstat
);
  import r2g4_pkg::*;

  q_entry_t           mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_CW-1:0] count_r;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (!push && pop) count_r <= count_r - 1'b1;
    end
  end

  assign pop_entry   = mem[rd_ptr_r];
  assign fstat.count = count_r;
  assign fstat.empty = (count_r == '0);
  assign fstat.full  = (count_r == FIFO_CW'(FIFO_DEPTH));

endmodule

FILE: src/r2g4_back.sv
// Back end: packs levels into black/red plane bytes and drives the result word.
// Depends on r2g4_pkg; pops from r2g4_fifo.
module r2g4_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  r2g4_pkg::q_entry_t        pop_entry,
  input  logic                      empty,
  output logic                      pop,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [7:0]                out_black_plane_byte,
  output logic [7:0]                out_red_plane_byte,
  output logic [r2g4_pkg::CNT_W-1:0] out_byte_index,
  output logic                      out_frame_last
);
  import r2g4_pkg::*;

  logic [2:0]       bp_r, bp_e, bp_nxt;
  logic [7:0]       blk_r, blk_e, blk_nxt, blk_new;
  logic [7:0]       red_r, red_e, red_nxt, red_new;
  logic [CNT_W-1:0] cnt_r, cnt_e, cnt_nxt;
  logic             out_v_r, out_v_nxt;
  logic [7:0]       ob_r, or_r;
  logic [CNT_W-1:0] oi_r;
  logic             ol_r;
  logic             done, last, can_emit;
  logic [2:0]       sh;

  always_comb begin
    bp_e  = pop_entry.frame_start ? 3'd0 : bp_r;
    blk_e = pop_entry.frame_start ? 8'd0 : blk_r;
    red_e = pop_entry.frame_start ? 8'd0 : red_r;
    cnt_e = pop_entry.frame_start ? '0 : cnt_r;
    sh      = 3'd7 - bp_e;
    blk_new = blk_e | (8'(pop_entry.level[1]) << sh);
    red_new = red_e | (8'(pop_entry.level[0]) << sh);
    done    = (bp_e == 3'd7);
    last    = (cnt_e == LAST_BYTE_IDX);
    can_emit = ~out_v_r | ~out_stall;
    pop     = ~empty & (~done | can_emit);

    bp_nxt    = bp_r;
    blk_nxt   = blk_r;
    red_nxt   = red_r;
    cnt_nxt   = cnt_r;
    out_v_nxt = out_v_r & out_stall;
    if (pop) begin
      if (done) begin
        bp_nxt    = 3'd0;
        blk_nxt   = 8'd0;
        red_nxt   = 8'd0;
        cnt_nxt   = last ? '0 : cnt_e + 1'b1;
        out_v_nxt = 1'b1;
      end else begin
        bp_nxt  = bp_e + 1'b1;
        blk_nxt = blk_new;
        red_nxt = red_new;
        cnt_nxt = cnt_e;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bp_r    <= 3'd0;
      blk_r   <= 8'd0;
      red_r   <= 8'd0;
      cnt_r   <= '0;
      out_v_r <= 1'b0;
    end else begin
      bp_r    <= bp_nxt;
      blk_r   <= blk_nxt;
      red_r   <= red_nxt;
      cnt_r   <= cnt_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && done) begin
      ob_r <= blk_new;
      or_r <= red_new;
      oi_r <= cnt_e;
      ol_r <= last;
    end
  end

  assign out_valid            = out_v_r;
  assign out_black_plane_byte = ob_r;
  assign out_red_plane_byte   = or_r;
  assign out_byte_index       = oi_r;
  assign out_frame_last       = ol_r;

endmodule

FILE: src/rgb_to_gray4_bitplane_packer.sv
// Top level of the RGB to 4-level gray bit-plane packer; holds the APB registers.
// Depends on r2g4_pkg, r2g4_front, r2g4_fifo, r2g4_back and the defines header.
//
// Usage: one RGB pixel per input word (in_valid/in_stall), in_frame_start on
// the first pixel of a frame. Every eighth pixel yields one output word
// (out_valid/out_stall) with the black and red plane bytes (first pixel in
// bit 7), the byte index in the frame and frame_last on byte 16799.
// Throughput: one pixel per cycle while in_stall is low. The result word passes
// through the sum register, the luma multiply register, the queue and the
// packer output register, in that order.
// in_stall rises when the 4-entry queue plus the two front stages hold four
// pixels, so a stalled output backs up into the queue and then the input.
// Reset (rst_n low, synchronous) empties the pipeline and queue, clears the
// packer state and loads thresholds 64/128/192; pready is always high. Threshold
// writes at byte addresses 0, 4, 8 must come while the block is idle (unchecked).
`include "rgb_to_gray4_bitplane_packer_defines.svh"
module rgb_to_gray4_bitplane_packer (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  in_red,
  input  logic [7:0]                  in_green,
  input  logic [7:0]                  in_blue,
  input  logic                        in_frame_start,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [7:0]                  out_black_plane_byte,
  output logic [7:0]                  out_red_plane_byte,
  output logic [r2g4_pkg::CNT_W-1:0]  out_byte_index,
  output logic                        out_frame_last,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [r2g4_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import r2g4_pkg::*;

  thr_t       thr_r;
  fifo_stat_t fstat;
  q_entry_t   push_entry, pop_entry;
  logic       fifo_push, fifo_pop;
  logic [1:0] reg_idx;
  logic       wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[CFG_AW-1:2];
  assign wr_en   = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r.l1 <= THR_W'(64);
      thr_r.l2 <= THR_W'(128);
      thr_r.l3 <= THR_W'(192);
    end else if (wr_en) begin
      case (reg_idx)
        REG_LEVEL1: thr_r.l1 <= pwdata[THR_W-1:0];
        REG_LEVEL2: thr_r.l2 <= pwdata[THR_W-1:0];
        REG_LEVEL3: thr_r.l3 <= pwdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_LEVEL1: prdata = 32'(thr_r.l1);
      REG_LEVEL2: prdata = 32'(thr_r.l2);
      REG_LEVEL3: prdata = 32'(thr_r.l3);
      default:    prdata = 32'd0;
    endcase
  end

  r2g4_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .in_frame_start (in_frame_start),
    .thr            (thr_r),
    .fstat          (fstat),
    .push           (fifo_push),
    .push_entry     (push_entry)
  );

  r2g4_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (fifo_push),
    .push_entry (push_entry),
    .pop        (fifo_pop),
    .pop_entry  (pop_entry),
    .fstat      (fstat)
  );

  r2g4_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .pop_entry            (pop_entry),
    .empty                (fstat.empty),
    .pop                  (fifo_pop),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_black_plane_byte (out_black_plane_byte),
    .out_red_plane_byte   (out_red_plane_byte),
    .out_byte_index       (out_byte_index),
    .out_frame_last       (out_frame_last)
  );

  `R2G4_ASSERT_IMPL(a_push_room, fifo_push, !fstat.full)
  `R2G4_ASSERT_IMPL(a_pop_data, fifo_pop, !fstat.empty)
  `R2G4_ASSERT_IMPL(a_last_idx, out_valid && out_frame_last, out_byte_index == LAST_BYTE_IDX)
  `R2G4_ASSERT_NEXT(a_credit, in_valid && !in_stall, !fstat.full)

endmodule
